[rtl/psg_tone_noise_generator_unit_assert.svh]
// ----------------------------------------------------------------------------
// psg assertion macros
// shared property shapes for the sound generator checks
// ----------------------------------------------------------------------------
`ifndef PSG_TONE_NOISE_GENERATOR_UNIT_ASSERT_SVH
`define PSG_TONE_NOISE_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define PSG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("psg check failed");

// next-cycle implication
`define PSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("psg check failed");

`endif

[rtl/psg_pkg.sv]
// ----------------------------------------------------------------------------
// psg_pkg
// types, constants and helper functions of the sound generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psg_pkg;

	localparam int SHIFT_WIDTH = 16;
	localparam int CNT_W       = 17;
	localparam int LEVEL_W     = 13;
	localparam int TONE_W      = 10;
	localparam int PERIOD_W    = 14;
	localparam int SAMPLE_W    = 15;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_POSITION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TAP_MASK          = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD     = 2'd2;

	// latched register codes (odd codes are attenuations)
	localparam logic [2:0] REG_TONE_A     = 3'd0;
	localparam logic [2:0] REG_TONE_B     = 3'd2;
	localparam logic [2:0] REG_TONE_C     = 3'd4;
	localparam logic [2:0] REG_NOISE_CTRL = 3'd6;

	localparam logic [1:0] NOISE_TRACK_TONE = 2'd3;
	localparam logic [PERIOD_W-1:0] NOISE_BASE_PERIOD = 14'd512;

	localparam logic [31:0] SEED_FULL = 32'h0000_8000;
	localparam logic [SHIFT_WIDTH-1:0] SHIFT_RESET = SEED_FULL[SHIFT_WIDTH-1:0];

	localparam logic [CFG_W-1:0] TAP_RESET    = 16'd9;
	localparam logic [CFG_W-1:0] SAMPLE_RESET = 16'd81;
	localparam logic [3:0]       FB_RESET     = 4'd15;

	localparam logic signed [CNT_W-1:0] CNT_FLOOR   = {1'b1, {(CNT_W-1){1'b0}}};
	localparam logic signed [CNT_W:0]   CNT_FLOOR_X = {2'b11, {(CNT_W-1){1'b0}}};

	typedef struct packed {
		logic [3:0]       fb_pos;
		logic [CFG_W-1:0] tap_mask;
		logic [CFG_W-1:0] sample_period;
	} cfg_t;

	typedef struct packed {
		logic [2:0][TONE_W-1:0]  tone_period;
		logic [PERIOD_W-1:0]     noise_period;
		logic [3:0][LEVEL_W-1:0] level;
		logic                    white;
		logic                    track;
		logic                    reseed;
	} regs_t;

	function automatic logic [LEVEL_W-1:0] level_lut(input logic [3:0] att);
		logic [LEVEL_W-1:0] v;
		case (att)
			4'd0:    v = 13'd8191;
			4'd1:    v = 13'd6506;
			4'd2:    v = 13'd5167;
			4'd3:    v = 13'd4104;
			4'd4:    v = 13'd3259;
			4'd5:    v = 13'd2588;
			4'd6:    v = 13'd2055;
			4'd7:    v = 13'd1632;
			4'd8:    v = 13'd1296;
			4'd9:    v = 13'd1029;
			4'd10:   v = 13'd817;
			4'd11:   v = 13'd648;
			4'd12:   v = 13'd514;
			4'd13:   v = 13'd408;
			4'd14:   v = 13'd324;
			default: v = 13'd0;
		endcase
		return v;
	endfunction

	// subtract elapsed cycles, saturating at the signed minimum
	function automatic logic signed [CNT_W-1:0] count_down(
		input logic signed [CNT_W-1:0] c,
		input logic [7:0]              cyc
	);
		logic signed [CNT_W:0] d;
		d = $signed({c[CNT_W-1], c}) - $signed({{(CNT_W-7){1'b0}}, cyc});
		if (d < CNT_FLOOR_X)
			return CNT_FLOOR;
		return d[CNT_W-1:0];
	endfunction

	function automatic logic not_positive(input logic signed [CNT_W-1:0] c);
		return c[CNT_W-1] || (c == '0);
	endfunction

endpackage

[rtl/psg_if.sv]
// ----------------------------------------------------------------------------
// psg stream interfaces
// valid/ready channels for input items and mixed samples
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface psg_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] write_byte;
	logic [7:0] step_cycles;

	modport source (output valid, output op, output write_byte, output step_cycles,
		input ready);
	modport sink (input valid, input op, input write_byte, input step_cycles,
		output ready);
endinterface

interface psg_out_if;
	logic        valid;
	logic        ready;
	logic [14:0] mixed_sample;

	modport source (output valid, output mixed_sample, input ready);
	modport sink (input valid, input mixed_sample, output ready);
endinterface

[rtl/psg_write_dec.sv]
// ----------------------------------------------------------------------------
// psg_write_dec
// write byte decoder holding periods, levels and noise control
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psg_write_dec import psg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [7:0] wr_byte,
	output regs_t      regs
);

	logic [2:0]              latched_q;
	logic [2:0]              sel;
	logic                    latch;
	logic [2:0][TONE_W-1:0]  tone_q;
	logic [PERIOD_W-1:0]     noise_period_q;
	logic [3:0][LEVEL_W-1:0] level_q;
	logic                    white_q;
	logic                    track_q;

	assign latch = wr_byte[7];
	assign sel   = latch ? wr_byte[6:4] : latched_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_q      <= '0;
			tone_q         <= '0;
			noise_period_q <= '0;
			level_q        <= '0;
			white_q        <= 1'b0;
			track_q        <= 1'b0;
		end else if (wr_en) begin
			latched_q <= sel;
			if (sel[0]) begin
				level_q[sel[2:1]] <= level_lut(wr_byte[3:0]);
			end else begin
				case (sel) inside
					REG_TONE_A, REG_TONE_B, REG_TONE_C: begin
						if (latch)
							tone_q[sel[2:1]][3:0] <= wr_byte[3:0];
						else
							tone_q[sel[2:1]][TONE_W-1:4] <= wr_byte[5:0];
					end
					REG_NOISE_CTRL: begin
						if (wr_byte[1:0] != NOISE_TRACK_TONE) begin
							noise_period_q <= NOISE_BASE_PERIOD << wr_byte[1:0];
							track_q        <= 1'b0;
						end else begin
							track_q <= 1'b1;
						end
						white_q <= wr_byte[2];
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		regs.tone_period  = tone_q;
		regs.noise_period = noise_period_q;
		regs.level        = level_q;
		regs.white        = white_q;
		regs.track        = track_q;
		regs.reseed       = wr_en && (sel == REG_NOISE_CTRL);
	end

endmodule

[rtl/psg_chan_step.sv]
// ----------------------------------------------------------------------------
// psg_chan_step
// tone and noise counters, lfsr, rate counter and mixer for one time step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psg_chan_step import psg_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  logic [7:0]          cycles,
	input  regs_t               regs,
	input  cfg_t                cfg,
	output logic                emit,
	output logic [SAMPLE_W-1:0] sample
);

	logic signed [3:0][CNT_W-1:0] cnt_q, cnt_d;
	logic [3:0]                   bits_q, bits_d;
	logic [SHIFT_WIDTH-1:0]       shift_q, shift_d;
	logic signed [CNT_W-1:0]      rate_q, rate_d;
	logic [SHIFT_WIDTH-1:0]       seed;
	logic [SHIFT_WIDTH-1:0]       taps;
	logic [31:0]                  seed_full;
	logic [31:0]                  taps_full;
	logic                         fb;
	logic signed [CNT_W-1:0]      dec;
	logic [PERIOD_W:0]            noise_reload;
	logic [SAMPLE_W-1:0]          mix;

	assign seed_full = 32'd1 << cfg.fb_pos;
	assign seed      = seed_full[SHIFT_WIDTH-1:0];
	assign taps_full = {16'd0, cfg.tap_mask};
	assign taps      = taps_full[SHIFT_WIDTH-1:0];

	assign noise_reload = regs.track ? {regs.tone_period[2], 5'd0}
		: {1'b0, regs.noise_period};

	always_comb begin
		cnt_d   = cnt_q;
		bits_d  = bits_q;
		shift_d = shift_q;
		dec     = '0;
		fb      = 1'b0;
		for (int i = 0; i < 3; i++) begin
			// period settings of 0 or 1 park the tone high
			if (regs.tone_period[i] <= TONE_W'(1)) begin
				bits_d[i] = 1'b1;
			end else begin
				dec = count_down(cnt_q[i], cycles);
				if (not_positive(dec)) begin
					bits_d[i] = ~bits_q[i];
					cnt_d[i]  = dec + $signed({3'd0, regs.tone_period[i], 4'd0});
				end else begin
					cnt_d[i] = dec;
				end
			end
		end
		dec = count_down(cnt_q[3], cycles);
		cnt_d[3] = dec;
		if (not_positive(dec)) begin
			fb        = regs.white ? ^(shift_q & taps) : shift_q[0];
			shift_d   = (shift_q >> 1) | (fb ? seed : '0);
			bits_d[3] = shift_d[0];
			cnt_d[3]  = dec + $signed({2'b00, noise_reload});
		end
	end

	always_comb begin
		rate_d = count_down(rate_q, cycles);
		emit   = not_positive(rate_d);
		if (emit)
			rate_d = rate_d + $signed({1'b0, cfg.sample_period});
	end

	always_comb begin
		mix = '0;
		for (int i = 0; i < 4; i++)
			mix = mix + (bits_d[i] ? SAMPLE_W'(regs.level[i]) : '0);
	end

	assign sample = mix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			bits_q  <= '0;
			shift_q <= SHIFT_RESET;
			rate_q  <= '0;
		end else if (step_en) begin
			cnt_q   <= cnt_d;
			bits_q  <= bits_d;
			shift_q <= shift_d;
			rate_q  <= rate_d;
		end else if (regs.reseed) begin
			shift_q <= seed;
		end
	end

endmodule

[rtl/psg_tone_noise_generator_unit.sv]
// flow: an item is registered, then worked into the result register once the result slot is free;
// a mixed sample is given only for time steps on which the rate counter expires
// throughput: one item per cycle while the result side keeps up; set by the
// combinational update of the counters and the four-input mixer
// reset: all channel state cleared, lfsr seeded with its top bit, registers at defaults
`timescale 1ns / 1ps
`include "psg_tone_noise_generator_unit_assert.svh"
// ----------------------------------------------------------------------------
// psg_tone_noise_generator_unit
// three square tones and an lfsr noise channel, mixed and down-sampled
// ----------------------------------------------------------------------------

module psg_tone_noise_generator_unit import psg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	psg_in_if.sink               item,
	psg_out_if.source            result
);

	cfg_t                cfg_q;
	logic                valid_s1;
	logic                op_s1;
	logic [7:0]          byte_s1;
	logic [7:0]          cycles_s1;
	logic                out_free;
	logic                proc;
	logic                res_valid_q;
	logic [SAMPLE_W-1:0] res_sample_q;
	regs_t               regs;
	logic                emit;
	logic [SAMPLE_W-1:0] sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fb_pos        <= FB_RESET;
			cfg_q.tap_mask      <= TAP_RESET;
			cfg_q.sample_period <= SAMPLE_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_FEEDBACK_POSITION: cfg_q.fb_pos        <= cfg_wdata[3:0];
				CFG_TAP_MASK:          cfg_q.tap_mask      <= cfg_wdata;
				CFG_SAMPLE_PERIOD:     cfg_q.sample_period <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// result slot is free or drains this cycle
	assign out_free   = !res_valid_q || result.ready;
	assign proc       = valid_s1 && out_free;
	assign item.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1     <= item.op;
			byte_s1   <= item.write_byte;
			cycles_s1 <= item.step_cycles;
		end
	end

	psg_write_dec u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (proc && !op_s1),
		.wr_byte (byte_s1),
		.regs    (regs)
	);

	psg_chan_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (proc && op_s1),
		.cycles  (cycles_s1),
		.regs    (regs),
		.cfg     (cfg_q),
		.emit    (emit),
		.sample  (sample)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (proc && op_s1 && emit) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && op_s1 && emit)
			res_sample_q <= sample;
	end

	assign result.valid        = res_valid_q;
	assign result.mixed_sample = res_sample_q;

	`PSG_ASSERT_NOW(a_no_take_when_blocked, clk, arst_n, valid_s1 && !out_free, !item.ready)
	`PSG_ASSERT_NEXT(a_emit_gives_result, clk, arst_n, proc && op_s1 && emit, result.valid)
	`PSG_ASSERT_NEXT(a_write_no_result, clk, arst_n, proc && !op_s1, !result.valid)
	`PSG_ASSERT_NOW(a_sample_range, clk, arst_n, result.valid, result.mixed_sample <= 15'd32764)

endmodule
